[hw/rtl/ant_tour_step_macros.svh]
// ------------------------------------------------------------------------
// ant_tour_step_macros.svh
// Assertion macros shared by the ant tour step block.
// ------------------------------------------------------------------------
`ifndef ANT_TOUR_STEP_MACROS_SVH
`define ANT_TOUR_STEP_MACROS_SVH

`ifndef SYNTH

// The condition must never be true outside reset.
`define ATS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// When pre holds, post must hold on the next clock edge.
`define ATS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ATS_ASSERT_NEVER(lbl, cond, msg)
`define ATS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[hw/rtl/ats_pkg.sv]
// ------------------------------------------------------------------------
// ats_pkg
// Types, constants and helpers shared by the ant tour step block.
// ------------------------------------------------------------------------
package ats_pkg;

	localparam int CITIES  = 32;
	localparam int CITY_W  = 5;
	localparam int LEN_W   = 16;
	localparam int TRAIL_W = 16;
	localparam int RND_W   = 16;
	localparam int DIST_W  = 21;
	localparam int ADDR_W  = $clog2(CITIES * CITIES);
	localparam int RAM_W   = LEN_W + TRAIL_W;
	localparam int WT_W    = TRAIL_W + 8;
	localparam int SUM_W   = WT_W + $clog2(CITIES);
	localparam int CNT_W   = $clog2(WT_W + 1);
	localparam int PROD_W  = SUM_W + RND_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_START = 2'd1;
	localparam logic [1:0] FN_STEP  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_RD,
		ST_EV,
		ST_DIV,
		ST_END1,
		ST_MUL,
		ST_BACK_RD,
		ST_BACK_EV,
		ST_PICK_RD,
		ST_PICK_EV,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		SEL_J,
		SEL_HOME,
		SEL_PICK
	} addr_sel_t;

	typedef struct packed {
		logic      clr_wr;
		logic      wr_road;
		logic      start_tour;
		logic      accept;
		logic      mark;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      div_start;
		logic      acc1;
		logic      acc2;
		logic      j_inc;
		logic      mul;
		logic      pick_first;
		logic      close_ev;
		logic      take_ev;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic finished;
		logic cand;
		logic div_done;
		logic j_last;
		logic first_v;
		logic sum_zero;
		logic hit;
	} sts_t;

	function automatic logic city_ok(input logic [CITY_W-1:0] c);
		return {1'b0, c} < (CITY_W + 1)'(CITIES);
	endfunction

endpackage

[hw/rtl/ats_ram.sv]
// ------------------------------------------------------------------------
// ats_ram
// Generic single write port, single read port RAM with registered read.
// ------------------------------------------------------------------------
module ats_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/ats_div.sv]
// ------------------------------------------------------------------------
// ats_div
// Restoring divider, one quotient bit per cycle, for the road weights.
// ------------------------------------------------------------------------
module ats_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ats_pkg::WT_W-1:0]  dividend,
	input  logic [ats_pkg::LEN_W-1:0] divisor,
	output logic                      done,
	output logic [ats_pkg::WT_W-1:0]  quotient
);

	logic [ats_pkg::LEN_W:0]   rem_q;
	logic [ats_pkg::WT_W-1:0]  quo_q;
	logic [ats_pkg::LEN_W-1:0] dvs_q;
	logic [ats_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [ats_pkg::LEN_W:0]   rem_sh;
	logic                      ge;
	logic [ats_pkg::LEN_W:0]   rem_nxt;

	assign rem_sh  = {rem_q[ats_pkg::LEN_W-1:0], quo_q[ats_pkg::WT_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_nxt = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ats_pkg::CNT_W'(ats_pkg::WT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ats_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[ats_pkg::WT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/ats_dp.sv]
// ------------------------------------------------------------------------
// ats_dp
// Datapath: road table, visited map, weight sum, roulette and tour state.
// ------------------------------------------------------------------------
module ats_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ats_pkg::cmd_t               cmd,
	output ats_pkg::sts_t               sts,
	input  logic [ats_pkg::CITY_W-1:0]  city_a,
	input  logic [ats_pkg::CITY_W-1:0]  city_b,
	input  logic [ats_pkg::LEN_W-1:0]   road_length,
	input  logic [ats_pkg::TRAIL_W-1:0] trail_level,
	input  logic [ats_pkg::RND_W-1:0]   random_fraction,
	output logic [ats_pkg::CITY_W-1:0]  next_city,
	output logic [ats_pkg::LEN_W-1:0]   step_length,
	output logic [ats_pkg::DIST_W-1:0]  tour_length,
	output logic                        moved,
	output logic                        tour_done
);

	logic [ats_pkg::ADDR_W-1:0]  clr_q;
	logic [ats_pkg::CITY_W-1:0]  cur_q;
	logic [ats_pkg::CITY_W-1:0]  home_q;
	logic [ats_pkg::CITY_W-1:0]  j_q;
	logic [ats_pkg::CITY_W-1:0]  pick_q;
	logic [ats_pkg::CITY_W-1:0]  first_q;
	logic                        first_v_q;
	logic [ats_pkg::DIST_W-1:0]  dist_q;
	logic                        fin_q;
	logic [ats_pkg::LEN_W-1:0]   taken_q;
	logic                        moved_q;
	logic [ats_pkg::RND_W-1:0]   rnd_q;
	logic [ats_pkg::SUM_W-1:0]   sum_q;
	logic [ats_pkg::SUM_W-1:0]   run_q;
	logic [ats_pkg::SUM_W-1:0]   target_q;
	logic [ats_pkg::CITIES-1:0]  visited_q;

	logic [ats_pkg::CITY_W-1:0]  col;
	logic [ats_pkg::ADDR_W-1:0]  raddr;
	logic                        we;
	logic [ats_pkg::ADDR_W-1:0]  waddr;
	logic [ats_pkg::RAM_W-1:0]   wdata;
	logic [ats_pkg::RAM_W-1:0]   rdata;
	logic [ats_pkg::LEN_W-1:0]   rd_len;
	logic [ats_pkg::TRAIL_W-1:0] rd_trail;
	logic                        div_done;
	logic [ats_pkg::WT_W-1:0]    quo;
	logic [ats_pkg::SUM_W-1:0]   run_nxt;
	logic [ats_pkg::DIST_W:0]    dist_sum;
	logic [ats_pkg::DIST_W-1:0]  dist_new;
	logic [ats_pkg::PROD_W-1:0]  prod;

	always_comb begin
		unique case (cmd.rd_sel)
			ats_pkg::SEL_J:    col = j_q;
			ats_pkg::SEL_HOME: col = home_q;
			ats_pkg::SEL_PICK: col = pick_q;
			default:           col = j_q;
		endcase
	end

	assign raddr = ats_pkg::ADDR_W'(cur_q) * ats_pkg::ADDR_W'(ats_pkg::CITIES)
		+ ats_pkg::ADDR_W'(col);

	always_comb begin
		if (cmd.clr_wr) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = cmd.wr_road && ats_pkg::city_ok(city_a) && ats_pkg::city_ok(city_b);
			waddr = ats_pkg::ADDR_W'(city_a) * ats_pkg::ADDR_W'(ats_pkg::CITIES)
				+ ats_pkg::ADDR_W'(city_b);
			wdata = {road_length, trail_level};
		end
	end

	ats_ram #(
		.WIDTH(ats_pkg::RAM_W),
		.DEPTH(ats_pkg::CITIES * ats_pkg::CITIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_len   = rdata[ats_pkg::RAM_W-1:ats_pkg::TRAIL_W];
	assign rd_trail = rdata[ats_pkg::TRAIL_W-1:0];

	ats_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({rd_trail, 8'h00}),
		.divisor  (rd_len),
		.done     (div_done),
		.quotient (quo)
	);

	assign run_nxt  = run_q + ats_pkg::SUM_W'(quo);
	assign dist_sum = {1'b0, dist_q} + (ats_pkg::DIST_W + 1)'(rd_len);
	assign dist_new = dist_sum[ats_pkg::DIST_W] ? ats_pkg::DIST_MAX
		: dist_sum[ats_pkg::DIST_W-1:0];
	assign prod     = ats_pkg::PROD_W'(rnd_q) * ats_pkg::PROD_W'(sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			cur_q     <= '0;
			home_q    <= '0;
			dist_q    <= '0;
			fin_q     <= 1'b0;
			visited_q <= '0;
			first_v_q <= 1'b0;
			taken_q   <= '0;
			moved_q   <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				taken_q <= '0;
				moved_q <= 1'b0;
			end
			if (cmd.start_tour && ats_pkg::city_ok(city_a)) begin
				home_q    <= city_a;
				cur_q     <= city_a;
				visited_q <= '0;
				dist_q    <= '0;
				fin_q     <= 1'b0;
			end
			if (cmd.mark) begin
				visited_q[cur_q] <= 1'b1;
				first_v_q        <= 1'b0;
			end
			if (cmd.acc1 && !first_v_q) begin
				first_v_q <= 1'b1;
			end
			if (cmd.close_ev) begin
				fin_q <= 1'b1;
				if (rd_len != '0) begin
					taken_q <= rd_len;
					moved_q <= 1'b1;
					dist_q  <= dist_new;
					cur_q   <= home_q;
				end
			end
			if (cmd.take_ev) begin
				taken_q <= rd_len;
				moved_q <= 1'b1;
				dist_q  <= dist_new;
				cur_q   <= pick_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rnd_q <= random_fraction;
		end
		if (cmd.mark || cmd.mul) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.mark) begin
			sum_q <= '0;
		end else if (cmd.acc1) begin
			sum_q <= sum_q + ats_pkg::SUM_W'(quo);
		end
		if (cmd.acc1 && !first_v_q) begin
			first_q <= j_q;
		end
		if (cmd.mul) begin
			target_q <= prod[ats_pkg::PROD_W-1:ats_pkg::RND_W];
			run_q    <= '0;
		end else if (cmd.acc2) begin
			run_q <= run_nxt;
		end
		if (cmd.pick_first) begin
			pick_q <= first_q;
		end else if (cmd.acc2 && (target_q < run_nxt)) begin
			pick_q <= j_q;
		end
	end

	always_comb begin
		sts.clr_last = clr_q == ats_pkg::ADDR_W'(ats_pkg::CITIES * ats_pkg::CITIES - 1);
		sts.finished = fin_q;
		sts.cand     = !visited_q[j_q] && (rd_len != '0);
		sts.div_done = div_done;
		sts.j_last   = j_q == ats_pkg::CITY_W'(ats_pkg::CITIES - 1);
		sts.first_v  = first_v_q;
		sts.sum_zero = sum_q == '0;
		sts.hit      = target_q < run_nxt;
	end

	assign next_city   = cur_q;
	assign step_length = taken_q;
	assign tour_length = dist_q;
	assign moved       = moved_q;
	assign tour_done   = fin_q;

endmodule

[hw/rtl/ats_ctrl.sv]
// ------------------------------------------------------------------------
// ats_ctrl
// Controller: sequences the clearing pass, up to two neighbor scans and the
// result beat.
// ------------------------------------------------------------------------
module ats_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	output logic          out_valid,
	input  logic          out_stall,
	input  ats_pkg::sts_t sts,
	output ats_pkg::cmd_t cmd
);

	ats_pkg::state_t state_q;
	ats_pkg::state_t state_d;
	logic            pass2_q;
	logic            acc_in;

	assign acc_in = in_valid && (state_q == ats_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ats_pkg::ST_CLEAR;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ats_pkg::ST_MARK) begin
				pass2_q <= 1'b0;
			end else if (state_q == ats_pkg::ST_MUL) begin
				pass2_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ats_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = ats_pkg::ST_IDLE;
			end
			ats_pkg::ST_IDLE: begin
				if (acc_in) begin
					if (func == ats_pkg::FN_STEP && !sts.finished) begin
						state_d = ats_pkg::ST_MARK;
					end else begin
						state_d = ats_pkg::ST_RESP;
					end
				end
			end
			ats_pkg::ST_MARK: state_d = ats_pkg::ST_RD;
			ats_pkg::ST_RD:   state_d = ats_pkg::ST_EV;
			ats_pkg::ST_EV: begin
				if (sts.cand) begin
					state_d = ats_pkg::ST_DIV;
				end else if (sts.j_last) begin
					state_d = pass2_q ? ats_pkg::ST_PICK_RD : ats_pkg::ST_END1;
				end else begin
					state_d = ats_pkg::ST_RD;
				end
			end
			ats_pkg::ST_DIV: begin
				if (sts.div_done) begin
					if (pass2_q && sts.hit) begin
						state_d = ats_pkg::ST_PICK_RD;
					end else if (sts.j_last) begin
						state_d = pass2_q ? ats_pkg::ST_PICK_RD : ats_pkg::ST_END1;
					end else begin
						state_d = ats_pkg::ST_RD;
					end
				end
			end
			ats_pkg::ST_END1: begin
				priority if (!sts.first_v) state_d = ats_pkg::ST_BACK_RD;
				else if (sts.sum_zero) state_d = ats_pkg::ST_PICK_RD;
				else state_d = ats_pkg::ST_MUL;
			end
			ats_pkg::ST_MUL:     state_d = ats_pkg::ST_RD;
			ats_pkg::ST_BACK_RD: state_d = ats_pkg::ST_BACK_EV;
			ats_pkg::ST_BACK_EV: state_d = ats_pkg::ST_RESP;
			ats_pkg::ST_PICK_RD: state_d = ats_pkg::ST_PICK_EV;
			ats_pkg::ST_PICK_EV: state_d = ats_pkg::ST_RESP;
			ats_pkg::ST_RESP: begin
				if (!out_stall) state_d = ats_pkg::ST_IDLE;
			end
			default: state_d = ats_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = ats_pkg::SEL_J;
		unique case (state_q)
			ats_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
			ats_pkg::ST_IDLE: begin
				cmd.accept     = acc_in;
				cmd.wr_road    = acc_in && (func == ats_pkg::FN_WRITE);
				cmd.start_tour = acc_in && (func == ats_pkg::FN_START);
			end
			ats_pkg::ST_MARK: cmd.mark = 1'b1;
			ats_pkg::ST_RD:   cmd.rd_en = 1'b1;
			ats_pkg::ST_EV: begin
				cmd.div_start  = sts.cand;
				cmd.j_inc      = !sts.cand && !sts.j_last;
				cmd.pick_first = !sts.cand && sts.j_last && pass2_q;
			end
			ats_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.acc1       = !pass2_q;
					cmd.acc2       = pass2_q;
					cmd.j_inc      = !(pass2_q && sts.hit) && !sts.j_last;
					cmd.pick_first = pass2_q && !sts.hit && sts.j_last;
				end
			end
			ats_pkg::ST_END1: begin
				cmd.pick_first = sts.first_v && sts.sum_zero;
			end
			ats_pkg::ST_MUL: cmd.mul = 1'b1;
			ats_pkg::ST_BACK_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ats_pkg::SEL_HOME;
			end
			ats_pkg::ST_BACK_EV: cmd.close_ev = 1'b1;
			ats_pkg::ST_PICK_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ats_pkg::SEL_PICK;
			end
			ats_pkg::ST_PICK_EV: cmd.take_ev = 1'b1;
			ats_pkg::ST_RESP: cmd = '0;
			default: cmd = '0;
		endcase
	end

	assign in_stall  = state_q != ats_pkg::ST_IDLE;
	assign out_valid = state_q == ats_pkg::ST_RESP;

endmodule

[hw/rtl/ant_tour_step.sv]
// Sequence: a write or start beat gives its result in the cycle after acceptance; a
// step scans every city, running the bit-serial weight divider per candidate, then
// rescans to the roulette pick; with no candidate or a zero weight sum, it does not.
// Throughput: one item at a time; the next beat is taken once the result is taken.
// Reset: asynchronous; afterwards a clearing pass over all CITIES*CITIES (1024) entries
// zeroes the road table, and no beat is accepted until it ends.
// ------------------------------------------------------------------------
// ant_tour_step
// Top level: builds one ant's tour by roulette selection over a road graph.
// ------------------------------------------------------------------------
`include "ant_tour_step_macros.svh"

module ant_tour_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [ats_pkg::CITY_W-1:0]  city_a,
	input  logic [ats_pkg::CITY_W-1:0]  city_b,
	input  logic [ats_pkg::LEN_W-1:0]   road_length,
	input  logic [ats_pkg::TRAIL_W-1:0] trail_level,
	input  logic [ats_pkg::RND_W-1:0]   random_fraction,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ats_pkg::CITY_W-1:0]  next_city,
	output logic [ats_pkg::LEN_W-1:0]   step_length,
	output logic [ats_pkg::DIST_W-1:0]  tour_length,
	output logic                        moved,
	output logic                        tour_done
);

	ats_pkg::cmd_t cmd;
	ats_pkg::sts_t sts;

	ats_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ats_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.city_a          (city_a),
		.city_b          (city_b),
		.road_length     (road_length),
		.trail_level     (trail_level),
		.random_fraction (random_fraction),
		.next_city       (next_city),
		.step_length     (step_length),
		.tour_length     (tour_length),
		.moved           (moved),
		.tour_done       (tour_done)
	);

	// Only one item is in flight, so a result and a new beat never meet.
	`ATS_ASSERT_NEVER(a_no_overlap, out_valid && !in_stall, "input taken while result pending")
	`ATS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block not busy after an accepted beat")
	`ATS_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid,
		"result beat repeated")
	`ATS_ASSERT_NEVER(a_moved_done, out_valid && moved && step_length == '0,
		"move reported over a missing road")

endmodule
